/* rtl/cpu_opcode_block0_execute_top_macros.svh */
// Assertion macros shared by the instruction execute block.
`ifndef CPU_OPCODE_BLOCK0_EXECUTE_TOP_MACROS_SVH
`define CPU_OPCODE_BLOCK0_EXECUTE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication or plain property on every rising edge outside reset.
`define COB0_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cob0 assertion failed");

// Check that a condition never holds outside reset.
`define COB0_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("cob0 forbidden condition seen");

`else

`define COB0_ASSERT(lbl, clk, rst_n, prop)
`define COB0_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/cob0_pkg.sv */
// Types, codes and helper functions for the opcode block 0 execute unit.
package cob0_pkg;

	// Flag bits
	localparam logic [7:0] FLAG_Z = 8'b1000_0000;
	localparam logic [7:0] FLAG_N = 8'b0100_0000;
	localparam logic [7:0] FLAG_H = 8'b0010_0000;
	localparam logic [7:0] FLAG_C = 8'b0001_0000;
	localparam logic [7:0] MASK_KEEP_Z = 8'h8f;
	localparam logic [7:0] MASK_KEEP_NC = 8'h1f;
	localparam logic [7:0] MASK_DAA_KEEP = 8'h4f;
	localparam logic [7:0] MASK_CCF_KEEP = 8'h9f;
	localparam logic [7:0] DAA_LIMIT = 8'h9a;
	localparam logic [7:0] DAA_CORR_LO = 8'h06;
	localparam logic [7:0] DAA_CORR_HI = 8'h60;
	localparam logic [3:0] DAA_NIBBLE_MAX = 4'h9;

	// Full opcodes with their own behavior
	localparam logic [5:0] OP_LD_A16_SP = 6'h08;
	localparam logic [5:0] OP_STOP = 6'h10;
	localparam logic [5:0] OP_JR = 6'h18;
	localparam logic [5:0] OP_JR_COND = 6'h20;

	// Instruction groups, taken from the low three opcode bits
	localparam logic [2:0] GRP_MISC0 = 3'd0;
	localparam logic [2:0] GRP_PAIR16 = 3'd1;
	localparam logic [2:0] GRP_LD_IND = 3'd2;
	localparam logic [2:0] GRP_INCDEC16 = 3'd3;
	localparam logic [2:0] GRP_INC8 = 3'd4;
	localparam logic [2:0] GRP_DEC8 = 3'd5;
	localparam logic [2:0] GRP_LD_D8 = 3'd6;

	// 8-bit register codes
	localparam logic [2:0] R_B = 3'd0;
	localparam logic [2:0] R_C = 3'd1;
	localparam logic [2:0] R_D = 3'd2;
	localparam logic [2:0] R_E = 3'd3;
	localparam logic [2:0] R_H = 3'd4;
	localparam logic [2:0] R_L = 3'd5;
	localparam logic [2:0] R_MEM = 3'd6;
	localparam logic [2:0] R_A = 3'd7;

	// Accumulator and flag operations of the last group
	localparam logic [2:0] AOP_RLCA = 3'd0;
	localparam logic [2:0] AOP_RRCA = 3'd1;
	localparam logic [2:0] AOP_RLA = 3'd2;
	localparam logic [2:0] AOP_RRA = 3'd3;
	localparam logic [2:0] AOP_DAA = 3'd4;
	localparam logic [2:0] AOP_CPL = 3'd5;
	localparam logic [2:0] AOP_SCF = 3'd6;

	// Register pair codes
	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	// Cycle counts
	localparam logic [4:0] CYC_0 = 5'd0;
	localparam logic [4:0] CYC_4 = 5'd4;
	localparam logic [4:0] CYC_8 = 5'd8;
	localparam logic [4:0] CYC_12 = 5'd12;
	localparam logic [4:0] CYC_20 = 5'd20;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] f;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		logic [7:0] e;
		logic [7:0] h;
		logic [7:0] l;
		logic [15:0] sp;
		logic [15:0] pc;
	} cob0_state_t;

	typedef struct packed {
		logic [5:0] opcode;
		logic [15:0] immediate;
		logic [7:0] mem_data;
	} cob0_item_t;

	typedef struct packed {
		logic [4:0] cycles;
		logic [15:0] access_address;
		logic write_enable;
		logic write_word;
		logic [15:0] write_data;
		logic [15:0] next_pc;
		logic [7:0] acc_out;
		logic [7:0] flags_out;
	} cob0_result_t;

	function automatic logic [15:0] pair_get(input cob0_state_t st, input logic [1:0] p);
		logic [15:0] v;
		case (p)
			PAIR_BC: v = {st.b, st.c};
			PAIR_DE: v = {st.d, st.e};
			PAIR_HL: v = {st.h, st.l};
			default: v = st.sp;
		endcase
		return v;
	endfunction

	function automatic cob0_state_t pair_set(input cob0_state_t st, input logic [1:0] p,
			input logic [15:0] v);
		cob0_state_t ns;
		ns = st;
		case (p)
			PAIR_BC: begin
				ns.b = v[15:8];
				ns.c = v[7:0];
			end
			PAIR_DE: begin
				ns.d = v[15:8];
				ns.e = v[7:0];
			end
			PAIR_HL: begin
				ns.h = v[15:8];
				ns.l = v[7:0];
			end
			default: ns.sp = v;
		endcase
		return ns;
	endfunction

	function automatic logic [7:0] reg_get(input cob0_state_t st, input logic [2:0] r);
		logic [7:0] v;
		case (r)
			R_B: v = st.b;
			R_C: v = st.c;
			R_D: v = st.d;
			R_E: v = st.e;
			R_H: v = st.h;
			R_L: v = st.l;
			R_A: v = st.a;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic cob0_state_t reg_set(input cob0_state_t st, input logic [2:0] r,
			input logic [7:0] v);
		cob0_state_t ns;
		ns = st;
		case (r)
			R_B: ns.b = v;
			R_C: ns.c = v;
			R_D: ns.d = v;
			R_E: ns.e = v;
			R_H: ns.h = v;
			R_L: ns.l = v;
			R_A: ns.a = v;
			default: ns = st;
		endcase
		return ns;
	endfunction

endpackage

/* rtl/cpu_opcode_block0_execute_top.sv */
// Top level of the opcode block 0 execute unit: input register, execute, result register.
//
// Usage:
//   Instructions arrive on the s_axis channel, one per transaction: opcode, the
//   16-bit immediate that follows it and the memory byte at the instruction's
//   data address. Each instruction yields exactly one result transaction on the
//   m_axis channel: cycle count, data access, store, next PC, A and F.
//   m_axis_tvalid rises once the instruction has waited in the input register and
//   then executed into the result register, which also commits the register file
//   so the next instruction sees the updated state. Throughput is one instruction
//   per clock while m_axis_tready stays high. When the receiver stalls, the result
//   register holds and the input register still takes one more instruction;
//   s_axis_tready then drops until the result is taken. Reset clears A, F, B..L,
//   SP and PC to zero and empties both stages.
module cpu_opcode_block0_execute_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[5:0], immediate[21:6], mem_data[29:22], zero[31:30]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// cycles[4:0], access_address[20:5], write_enable[21], write_word[22],
	// write_data[38:23], next_pc[54:39], acc_out[62:55], flags_out[70:63], zero[71]
	output logic [71:0] m_axis_tdata
);

	`include "cpu_opcode_block0_execute_top_macros.svh"

	cob0_pkg::cob0_item_t   item_s1;
	logic                   valid_s1;
	cob0_pkg::cob0_result_t result_q;
	logic                   out_valid_q;
	cob0_pkg::cob0_state_t  state;
	cob0_pkg::cob0_state_t  next_state;
	cob0_pkg::cob0_result_t result;
	logic                   advance;
	logic                   exec_go;
	logic                   in_fire;

	assign advance = !out_valid_q || m_axis_tready;
	assign exec_go = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (exec_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.opcode <= s_axis_tdata[5:0];
			item_s1.immediate <= s_axis_tdata[21:6];
			item_s1.mem_data <= s_axis_tdata[29:22];
		end
	end

	cob0_exec u_exec (
		.item       (item_s1),
		.state      (state),
		.next_state (next_state),
		.result     (result)
	);

	cob0_regfile u_regfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (exec_go),
		.next_state (next_state),
		.state      (state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result until the receiver takes the transaction
	always_ff @(posedge clk) begin
		if (exec_go) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, result_q.flags_out, result_q.acc_out, result_q.next_pc,
		result_q.write_data, result_q.write_word, result_q.write_enable,
		result_q.access_address, result_q.cycles};

	`COB0_ASSERT(a_exec_shows_result, clk, arst_n, exec_go |=> m_axis_tvalid)
	`COB0_ASSERT(a_ready_low_only_full, clk, arst_n,
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
	`COB0_ASSERT(a_stall_freezes_state, clk, arst_n,
		(out_valid_q && !m_axis_tready) |=> $stable(state))
	`COB0_ASSERT(a_result_matches_pc, clk, arst_n,
		out_valid_q |-> (result_q.next_pc == state.pc))
	`COB0_ASSERT(a_result_matches_acc_flags, clk, arst_n,
		out_valid_q |-> (result_q.acc_out == state.a && result_q.flags_out == state.f))
	`COB0_ASSERT_NEVER(a_word_store_without_store, clk, arst_n,
		out_valid_q && result_q.write_word && !result_q.write_enable)

endmodule

/* rtl/cob0_regfile.sv */
// Architectural register file: A, F, B..L, SP and PC, updated once per instruction.
module cob0_regfile (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  cob0_pkg::cob0_state_t next_state,
	output cob0_pkg::cob0_state_t state
);

	cob0_pkg::cob0_state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (commit) begin
			state_q <= next_state;
		end
	end

	assign state = state_q;

endmodule

/* rtl/cob0_exec.sv */
// Single-pass execute logic for one instruction of opcode block 0x00-0x3F.
module cob0_exec (
	input  cob0_pkg::cob0_item_t  item,
	input  cob0_pkg::cob0_state_t state,
	output cob0_pkg::cob0_state_t next_state,
	output cob0_pkg::cob0_result_t result
);

	logic [5:0] op;
	logic [2:0] r;
	logic [1:0] p;
	logic [15:0] hl;
	logic [15:0] rr;
	logic [16:0] sum;
	logic [12:0] sum_lo;
	logic [7:0] v;
	logic [7:0] a;
	logic [7:0] f;
	logic [7:0] corr;
	logic [7:0] daa_res;
	logic daa_carry;
	logic cond_bit;
	logic taken;
	logic jump;
	logic [1:0] len;
	logic [15:0] npc;
	cob0_pkg::cob0_state_t ns;
	cob0_pkg::cob0_result_t res;

	assign op = item.opcode;
	assign r = op[5:3];
	assign p = op[5:4];
	assign hl = {state.h, state.l};
	assign rr = cob0_pkg::pair_get(state, p);
	assign a = state.a;
	assign f = state.f;
	assign sum = {1'b0, hl} + {1'b0, rr};
	assign sum_lo = {1'b0, hl[11:0]} + {1'b0, rr[11:0]};

	// Decimal adjust of the accumulator
	always_comb begin
		corr = 8'h00;
		daa_carry = 1'b0;
		if ((f & cob0_pkg::FLAG_N) != 8'h00) begin
			if ((f & cob0_pkg::FLAG_H) != 8'h00) corr = corr + cob0_pkg::DAA_CORR_LO;
			if ((f & cob0_pkg::FLAG_C) != 8'h00) begin
				corr = corr + cob0_pkg::DAA_CORR_HI;
				daa_carry = 1'b1;
			end
			daa_res = a - corr;
		end else begin
			if ((f & cob0_pkg::FLAG_H) != 8'h00 || a[3:0] > cob0_pkg::DAA_NIBBLE_MAX)
				corr = corr + cob0_pkg::DAA_CORR_LO;
			if ((f & cob0_pkg::FLAG_C) != 8'h00 || a >= cob0_pkg::DAA_LIMIT) begin
				corr = corr + cob0_pkg::DAA_CORR_HI;
				daa_carry = 1'b1;
			end
			daa_res = a + corr;
		end
	end

	// Condition of a relative jump: opcode bit 4 picks C over Z, bit 3 the polarity
	assign cond_bit = r[1] ? ((f & cob0_pkg::FLAG_C) != 8'h00)
		: ((f & cob0_pkg::FLAG_Z) != 8'h00);
	assign taken = (op >= cob0_pkg::OP_JR_COND) ? (r[0] ? cond_bit : !cond_bit) : 1'b1;

	always_comb begin
		ns = state;
		res = '0;
		res.cycles = cob0_pkg::CYC_4;
		len = 2'd1;
		jump = 1'b0;
		v = 8'h00;
		case (op[2:0])
			cob0_pkg::GRP_MISC0: begin
				if (op == cob0_pkg::OP_LD_A16_SP) begin
					res.access_address = item.immediate;
					res.write_enable = 1'b1;
					res.write_word = 1'b1;
					res.write_data = state.sp;
					res.cycles = cob0_pkg::CYC_20;
					len = 2'd3;
				end else if (op == cob0_pkg::OP_STOP) begin
					res.cycles = cob0_pkg::CYC_0;
				end else if (op >= cob0_pkg::OP_JR) begin
					len = 2'd2;
					res.cycles = taken ? cob0_pkg::CYC_12 : cob0_pkg::CYC_8;
					jump = taken;
				end
			end
			cob0_pkg::GRP_PAIR16: begin
				if (op[3]) begin
					ns.f = (f & cob0_pkg::MASK_KEEP_Z)
						| (sum[16] ? cob0_pkg::FLAG_C : 8'h00)
						| (sum_lo[12] ? cob0_pkg::FLAG_H : 8'h00);
					ns = cob0_pkg::pair_set(ns, cob0_pkg::PAIR_HL, sum[15:0]);
					res.cycles = cob0_pkg::CYC_8;
				end else begin
					ns = cob0_pkg::pair_set(ns, p, item.immediate);
					res.cycles = cob0_pkg::CYC_12;
					len = 2'd3;
				end
			end
			cob0_pkg::GRP_LD_IND: begin
				res.access_address = (p == cob0_pkg::PAIR_BC || p == cob0_pkg::PAIR_DE) ? rr : hl;
				if (op[3]) begin
					ns.a = item.mem_data;
				end else begin
					res.write_enable = 1'b1;
					res.write_data = {8'h00, a};
				end
				// Post-increment or post-decrement of HL
				if (p == cob0_pkg::PAIR_HL) ns = cob0_pkg::pair_set(ns, cob0_pkg::PAIR_HL, hl + 16'd1);
				if (p == cob0_pkg::PAIR_SP) ns = cob0_pkg::pair_set(ns, cob0_pkg::PAIR_HL, hl - 16'd1);
				res.cycles = cob0_pkg::CYC_8;
			end
			cob0_pkg::GRP_INCDEC16: begin
				ns = cob0_pkg::pair_set(ns, p, op[3] ? rr - 16'd1 : rr + 16'd1);
				res.cycles = cob0_pkg::CYC_8;
			end
			cob0_pkg::GRP_INC8, cob0_pkg::GRP_DEC8: begin
				v = (r == cob0_pkg::R_MEM) ? item.mem_data : cob0_pkg::reg_get(state, r);
				if (op[2:0] == cob0_pkg::GRP_INC8) begin
					v = v + 8'd1;
					ns.f = (f & cob0_pkg::MASK_KEEP_NC)
						| ((v[3:0] == 4'h0) ? cob0_pkg::FLAG_H : 8'h00);
				end else begin
					v = v - 8'd1;
					ns.f = (f & cob0_pkg::MASK_KEEP_NC) | cob0_pkg::FLAG_N
						| ((v[3:0] == 4'hf) ? cob0_pkg::FLAG_H : 8'h00);
				end
				if (v == 8'h00) ns.f = ns.f | cob0_pkg::FLAG_Z;
				if (r == cob0_pkg::R_MEM) begin
					res.access_address = hl;
					res.write_enable = 1'b1;
					res.write_data = {8'h00, v};
					res.cycles = cob0_pkg::CYC_12;
				end else begin
					ns = cob0_pkg::reg_set(ns, r, v);
				end
			end
			cob0_pkg::GRP_LD_D8: begin
				v = item.immediate[7:0];
				len = 2'd2;
				if (r == cob0_pkg::R_MEM) begin
					res.access_address = hl;
					res.write_enable = 1'b1;
					res.write_data = {8'h00, v};
					res.cycles = cob0_pkg::CYC_12;
				end else begin
					ns = cob0_pkg::reg_set(ns, r, v);
					res.cycles = cob0_pkg::CYC_8;
				end
			end
			default: begin
				case (r)
					cob0_pkg::AOP_RLCA: begin
						ns.a = {a[6:0], a[7]};
						ns.f = {3'b000, a[7], 4'h0};
					end
					cob0_pkg::AOP_RRCA: begin
						ns.a = {a[0], a[7:1]};
						ns.f = {3'b000, a[0], 4'h0};
					end
					cob0_pkg::AOP_RLA: begin
						ns.a = {a[6:0], f[4]};
						ns.f = {3'b000, a[7], 4'h0};
					end
					cob0_pkg::AOP_RRA: begin
						ns.a = {f[4], a[7:1]};
						ns.f = {3'b000, a[0], 4'h0};
					end
					cob0_pkg::AOP_DAA: begin
						ns.a = daa_res;
						ns.f = (f & cob0_pkg::MASK_DAA_KEEP)
							| (daa_carry ? cob0_pkg::FLAG_C : 8'h00)
							| ((daa_res == 8'h00) ? cob0_pkg::FLAG_Z : 8'h00);
					end
					cob0_pkg::AOP_CPL: begin
						ns.a = ~a;
						ns.f = f | cob0_pkg::FLAG_N | cob0_pkg::FLAG_H;
					end
					cob0_pkg::AOP_SCF: begin
						ns.f = (f & cob0_pkg::MASK_KEEP_Z) | cob0_pkg::FLAG_C;
					end
					default: begin
						ns.f = (f ^ cob0_pkg::FLAG_C) & cob0_pkg::MASK_CCF_KEEP;
					end
				endcase
			end
		endcase
	end

	// Next PC: length, plus the sign-extended offset when the jump is taken
	assign npc = state.pc + {14'd0, len}
		+ (jump ? {{8{item.immediate[7]}}, item.immediate[7:0]} : 16'd0);

	always_comb begin
		next_state = ns;
		next_state.pc = npc;
		result = res;
		result.next_pc = npc;
		result.acc_out = ns.a;
		result.flags_out = ns.f;
	end

endmodule

/* verif/cpu_opcode_block0_execute_top_tb.sv */
// Testbench for the opcode block 0 execute unit: directed table, random stream, predictor check.
`timescale 1ns / 1ps

module cpu_opcode_block0_execute_top_tb;

	localparam logic [2:0] GRP_ACC = 3'd7;
	localparam logic [2:0] AOP_CCF = 3'd7;
	localparam logic [5:0] OPC_NOP = 6'h00;
	localparam logic [5:0] OPC_JR_C = 6'h38;
	localparam int RANDOM_INSNS = 650;
	localparam int PAUSE_AT = 150;
	localparam int QUIET_SEND_AT = 530;
	localparam int LONG_HOLD_AT = 300;
	localparam int QUIET_RECV_AT = 560;

	typedef struct packed {
		logic [5:0] op;
		logic [15:0] imm;
		logic [7:0] mem;
		logic checked;
		cob0_pkg::cob0_result_t want;
	} insn_row_t;

	// Rows with checked set carry results read straight off the instruction set
	localparam insn_row_t DIRECTED [25] = '{
		'{OPC_NOP, 16'h0000, 8'h00, 1'b1,
			'{cob0_pkg::CYC_4, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0001, 8'h00, 8'h00}},
		'{cob0_pkg::OP_STOP, 16'hffff, 8'hff, 1'b1,
			'{cob0_pkg::CYC_0, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0002, 8'h00, 8'h00}},
		'{{cob0_pkg::PAIR_SP, 1'b0, cob0_pkg::GRP_PAIR16}, 16'hffff, 8'h00, 1'b1,
			'{cob0_pkg::CYC_12, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0005, 8'h00, 8'h00}},
		'{cob0_pkg::OP_LD_A16_SP, 16'hffff, 8'h00, 1'b1,
			'{cob0_pkg::CYC_20, 16'hffff, 1'b1, 1'b1, 16'hffff, 16'h0008, 8'h00, 8'h00}},
		'{{cob0_pkg::PAIR_SP, 1'b0, cob0_pkg::GRP_INCDEC16}, 16'h0000, 8'h00, 1'b1,
			'{cob0_pkg::CYC_8, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0009, 8'h00, 8'h00}},
		'{{cob0_pkg::R_A, cob0_pkg::GRP_LD_D8}, 16'habff, 8'h00, 1'b1,
			'{cob0_pkg::CYC_8, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h000b, 8'hff, 8'h00}},
		'{{cob0_pkg::R_A, cob0_pkg::GRP_INC8}, 16'h0000, 8'h00, 1'b1,
			'{cob0_pkg::CYC_4, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h000c, 8'h00, 8'ha0}},
		'{{cob0_pkg::R_A, cob0_pkg::GRP_DEC8}, 16'h0000, 8'h00, 1'b1,
			'{cob0_pkg::CYC_4, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h000d, 8'hff, 8'h60}},
		'{{cob0_pkg::PAIR_HL, 1'b0, cob0_pkg::GRP_PAIR16}, 16'hffff, 8'h00, 1'b0, '0},
		'{{cob0_pkg::PAIR_HL, 1'b0, cob0_pkg::GRP_INCDEC16}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::PAIR_HL, 1'b1, cob0_pkg::GRP_INCDEC16}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::PAIR_HL, 1'b1, cob0_pkg::GRP_PAIR16}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::PAIR_HL, 1'b0, cob0_pkg::GRP_LD_IND}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::PAIR_SP, 1'b1, cob0_pkg::GRP_LD_IND}, 16'h0000, 8'h9a, 1'b0, '0},
		'{{cob0_pkg::R_MEM, cob0_pkg::GRP_INC8}, 16'h0000, 8'hff, 1'b0, '0},
		'{{cob0_pkg::R_MEM, cob0_pkg::GRP_DEC8}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::R_MEM, cob0_pkg::GRP_LD_D8}, 16'h125a, 8'h00, 1'b0, '0},
		'{{cob0_pkg::AOP_DAA, GRP_ACC}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::AOP_RLCA, GRP_ACC}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::AOP_RRA, GRP_ACC}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::AOP_CPL, GRP_ACC}, 16'h0000, 8'h00, 1'b0, '0},
		'{{cob0_pkg::AOP_SCF, GRP_ACC}, 16'h0000, 8'h00, 1'b0, '0},
		'{OPC_JR_C, 16'h007f, 8'h00, 1'b0, '0},
		'{{AOP_CCF, GRP_ACC}, 16'h0000, 8'h00, 1'b0, '0},
		'{cob0_pkg::OP_JR, 16'h0080, 8'h00, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// opcode[5:0], immediate[21:6], mem_data[29:22], zero[31:30]
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// cycles[4:0], access_address[20:5], write_enable[21], write_word[22],
	// write_data[38:23], next_pc[54:39], acc_out[62:55], flags_out[70:63], zero[71]
	logic [71:0] m_axis_tdata;

	// Predicted CPU state
	logic [7:0]  cpu_a, cpu_f;
	logic [7:0]  cpu_r [6];
	logic [15:0] cpu_sp, cpu_pc;

	cob0_pkg::cob0_result_t pending_results [$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          rx_hold = 0;
	logic        long_hold_done = 1'b0;

	cpu_opcode_block0_execute_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] read_pair(input logic [1:0] p);
		if (p == cob0_pkg::PAIR_SP)
			return cpu_sp;
		return {cpu_r[{p, 1'b0}], cpu_r[{p, 1'b1}]};
	endfunction

	function automatic void write_pair(input logic [1:0] p, input logic [15:0] v);
		if (p == cob0_pkg::PAIR_SP) begin
			cpu_sp = v;
		end else begin
			cpu_r[{p, 1'b0}] = v[15:8];
			cpu_r[{p, 1'b1}] = v[7:0];
		end
	endfunction

	// Execute one instruction on the predicted state and return its result
	function automatic cob0_pkg::cob0_result_t execute_insn(input logic [5:0] op,
			input logic [15:0] imm, input logic [7:0] mem);
		cob0_pkg::cob0_result_t res;
		logic [2:0]  r;
		logic [1:0]  p;
		logic [15:0] hl, rr, npc;
		logic [16:0] sum;
		logic [12:0] half_sum;
		logic [7:0]  f, a, v, corr;
		logic        taken, flag_bit, carry, jump;
		int          len;
		r = op[5:3];
		p = op[5:4];
		res = '0;
		res.cycles = cob0_pkg::CYC_4;
		len = 1;
		jump = 1'b0;
		f = cpu_f;
		a = cpu_a;
		hl = read_pair(cob0_pkg::PAIR_HL);
		case (op[2:0])
			cob0_pkg::GRP_MISC0: begin
				if (op == cob0_pkg::OP_LD_A16_SP) begin
					res.access_address = imm;
					res.write_enable = 1'b1;
					res.write_word = 1'b1;
					res.write_data = cpu_sp;
					res.cycles = cob0_pkg::CYC_20;
					len = 3;
				end else if (op == cob0_pkg::OP_STOP) begin
					res.cycles = cob0_pkg::CYC_0;
				end else if (op >= cob0_pkg::OP_JR) begin
					taken = 1'b1;
					if (op >= cob0_pkg::OP_JR_COND) begin
						flag_bit = op[4] ? ((f & cob0_pkg::FLAG_C) != 0)
							: ((f & cob0_pkg::FLAG_Z) != 0);
						taken = op[3] ? flag_bit : !flag_bit;
					end
					len = 2;
					res.cycles = taken ? cob0_pkg::CYC_12 : cob0_pkg::CYC_8;
					jump = taken;
				end
			end
			cob0_pkg::GRP_PAIR16: begin
				if (op[3]) begin
					rr = read_pair(p);
					sum = {1'b0, hl} + {1'b0, rr};
					half_sum = {1'b0, hl[11:0]} + {1'b0, rr[11:0]};
					f = f & cob0_pkg::MASK_KEEP_Z;
					if (sum[16])
						f = f | cob0_pkg::FLAG_C;
					if (half_sum[12])
						f = f | cob0_pkg::FLAG_H;
					write_pair(cob0_pkg::PAIR_HL, sum[15:0]);
					res.cycles = cob0_pkg::CYC_8;
				end else begin
					write_pair(p, imm);
					res.cycles = cob0_pkg::CYC_12;
					len = 3;
				end
			end
			cob0_pkg::GRP_LD_IND: begin
				res.access_address = (p == cob0_pkg::PAIR_BC || p == cob0_pkg::PAIR_DE)
					? read_pair(p) : hl;
				if (op[3]) begin
					cpu_a = mem;
				end else begin
					res.write_enable = 1'b1;
					res.write_data = {8'h00, cpu_a};
				end
				if (p == cob0_pkg::PAIR_HL)
					write_pair(cob0_pkg::PAIR_HL, hl + 16'd1);
				if (p == cob0_pkg::PAIR_SP)
					write_pair(cob0_pkg::PAIR_HL, hl - 16'd1);
				res.cycles = cob0_pkg::CYC_8;
			end
			cob0_pkg::GRP_INCDEC16: begin
				rr = read_pair(p);
				write_pair(p, op[3] ? rr - 16'd1 : rr + 16'd1);
				res.cycles = cob0_pkg::CYC_8;
			end
			cob0_pkg::GRP_INC8, cob0_pkg::GRP_DEC8: begin
				v = (r == cob0_pkg::R_MEM) ? mem : (r == cob0_pkg::R_A) ? cpu_a : cpu_r[r];
				if (op[2:0] == cob0_pkg::GRP_INC8) begin
					v = v + 8'd1;
					f = f & cob0_pkg::MASK_KEEP_NC;
					if (v[3:0] == 4'h0)
						f = f | cob0_pkg::FLAG_H;
				end else begin
					v = v - 8'd1;
					f = (f & cob0_pkg::MASK_KEEP_NC) | cob0_pkg::FLAG_N;
					if (v[3:0] == 4'hf)
						f = f | cob0_pkg::FLAG_H;
				end
				if (v == 8'h00)
					f = f | cob0_pkg::FLAG_Z;
				if (r == cob0_pkg::R_MEM) begin
					res.access_address = hl;
					res.write_enable = 1'b1;
					res.write_data = {8'h00, v};
					res.cycles = cob0_pkg::CYC_12;
				end else if (r == cob0_pkg::R_A) begin
					cpu_a = v;
				end else begin
					cpu_r[r] = v;
				end
			end
			cob0_pkg::GRP_LD_D8: begin
				v = imm[7:0];
				len = 2;
				res.cycles = cob0_pkg::CYC_8;
				if (r == cob0_pkg::R_MEM) begin
					res.access_address = hl;
					res.write_enable = 1'b1;
					res.write_data = {8'h00, v};
					res.cycles = cob0_pkg::CYC_12;
				end else if (r == cob0_pkg::R_A) begin
					cpu_a = v;
				end else begin
					cpu_r[r] = v;
				end
			end
			default: begin
				case (r)
					cob0_pkg::AOP_RLCA: begin
						cpu_a = {a[6:0], a[7]};
						f = a[7] ? cob0_pkg::FLAG_C : 8'h00;
					end
					cob0_pkg::AOP_RRCA: begin
						cpu_a = {a[0], a[7:1]};
						f = a[0] ? cob0_pkg::FLAG_C : 8'h00;
					end
					cob0_pkg::AOP_RLA: begin
						cpu_a = {a[6:0], (f & cob0_pkg::FLAG_C) != 0};
						f = a[7] ? cob0_pkg::FLAG_C : 8'h00;
					end
					cob0_pkg::AOP_RRA: begin
						cpu_a = {(f & cob0_pkg::FLAG_C) != 0, a[7:1]};
						f = a[0] ? cob0_pkg::FLAG_C : 8'h00;
					end
					cob0_pkg::AOP_DAA: begin
						corr = 8'h00;
						carry = 1'b0;
						if ((f & cob0_pkg::FLAG_N) != 0) begin
							if ((f & cob0_pkg::FLAG_H) != 0)
								corr = corr + cob0_pkg::DAA_CORR_LO;
							if ((f & cob0_pkg::FLAG_C) != 0) begin
								corr = corr + cob0_pkg::DAA_CORR_HI;
								carry = 1'b1;
							end
							v = a - corr;
						end else begin
							if ((f & cob0_pkg::FLAG_H) != 0
									|| a[3:0] > cob0_pkg::DAA_NIBBLE_MAX)
								corr = corr + cob0_pkg::DAA_CORR_LO;
							if ((f & cob0_pkg::FLAG_C) != 0 || a >= cob0_pkg::DAA_LIMIT) begin
								corr = corr + cob0_pkg::DAA_CORR_HI;
								carry = 1'b1;
							end
							v = a + corr;
						end
						cpu_a = v;
						f = (f & cob0_pkg::MASK_DAA_KEEP & ~cob0_pkg::FLAG_C)
							| (carry ? cob0_pkg::FLAG_C : 8'h00)
							| (v == 8'h00 ? cob0_pkg::FLAG_Z : 8'h00);
					end
					cob0_pkg::AOP_CPL: begin
						cpu_a = ~a;
						f = f | cob0_pkg::FLAG_N | cob0_pkg::FLAG_H;
					end
					cob0_pkg::AOP_SCF: f = (f & cob0_pkg::MASK_KEEP_Z) | cob0_pkg::FLAG_C;
					default: f = (f ^ cob0_pkg::FLAG_C) & cob0_pkg::MASK_CCF_KEEP;
				endcase
			end
		endcase
		cpu_f = f;
		npc = cpu_pc + 16'(len);
		if (jump)
			npc = npc + {{8{imm[7]}}, imm[7:0]};
		cpu_pc = npc;
		res.next_pc = npc;
		res.acc_out = cpu_a;
		res.flags_out = cpu_f;
		return res;
	endfunction

	// Offer one instruction, hold it until accepted, then queue its expected result
	task automatic send_insn(input logic [5:0] op, input logic [15:0] imm, input logic [7:0] mem,
			input logic checked, input cob0_pkg::cob0_result_t want);
		cob0_pkg::cob0_result_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, mem, imm, op};
		do @(posedge clk); while (!s_axis_tready);
		predicted = execute_insn(op, imm, mem);
		pending_results.push_back(checked ? want : predicted);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		logic [15:0] imm_val;
		cpu_a = '0;
		cpu_f = '0;
		cpu_sp = '0;
		cpu_pc = '0;
		foreach (cpu_r[k])
			cpu_r[k] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[k])
			send_insn(DIRECTED[k].op, DIRECTED[k].imm, DIRECTED[k].mem, DIRECTED[k].checked,
				DIRECTED[k].want);
		for (int i = 0; i < RANDOM_INSNS; i++) begin
			if (i == PAUSE_AT) begin
				// drain everything before offering more
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end else if (i < QUIET_SEND_AT && $urandom_range(0, 4) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: imm_val = 16'h0000;
					1: imm_val = 16'hffff;
					2: imm_val = 16'h0080;
					default: imm_val = 16'h007f;
				endcase
			end else begin
				imm_val = 16'($urandom_range(0, 65535));
			end
			send_insn(6'($urandom_range(0, 63)), imm_val, 8'($urandom_range(0, 255)), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result side backpressure: random bursts, one long hold, quiet at the end
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else if (rx_hold != 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
			long_hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
			rx_hold <= 59;
		end else if (results_seen < QUIET_RECV_AT && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= $urandom_range(0, 6);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		cob0_pkg::cob0_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			got = '{m_axis_tdata[4:0], m_axis_tdata[20:5], m_axis_tdata[21], m_axis_tdata[22],
				m_axis_tdata[38:23], m_axis_tdata[54:39], m_axis_tdata[62:55],
				m_axis_tdata[70:63]};
			if (pending_results.size() == 0) begin
				$error("result transaction with no pending instruction");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("cycles", 16'(want.cycles), 16'(got.cycles));
				check_field("access_address", want.access_address, got.access_address);
				check_field("write_enable", 16'(want.write_enable), 16'(got.write_enable));
				check_field("write_word", 16'(want.write_word), 16'(got.write_word));
				check_field("write_data", want.write_data, got.write_data);
				check_field("next_pc", want.next_pc, got.next_pc);
				check_field("acc_out", 16'(want.acc_out), 16'(got.acc_out));
				check_field("flags_out", 16'(want.flags_out), 16'(got.flags_out));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/cob0_pkg.sv
rtl/cob0_regfile.sv
rtl/cob0_exec.sv
rtl/cpu_opcode_block0_execute_top.sv
verif/cpu_opcode_block0_execute_top_tb.sv
